@@ rtl/core/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int unsigned ADDR_W = 11;
    localparam int unsigned REQ_W  = 12;
    localparam int unsigned FREE_W = 12;

    localparam int unsigned HEAP_BYTES = 2048;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [REQ_W-1:0]  request_size;
    } req_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
        logic [FREE_W-1:0] free_bytes;
    } rsp_item_t;

endpackage

@@ rtl/core/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a table of contiguous heap blocks; the heap size
// comes from the package. Every operation runs through the same steps: the
// transfer is taken, one full turn of the ring of MAX_BLOCKS cells, rotating
// one entry a cycle, examines each entry at the head cell, a decision is made,
// a second full turn writes the changes back as the entries pass the head, and
// the result register is loaded. A result still waiting in that register holds
// the last step until it is taken. The next operation is taken once the result
// register is loaded.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int unsigned HEADER_BYTES = 16,
    parameter int unsigned MAX_BLOCKS   = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffha_pkg::req_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ffha_pkg::rsp_item_t  out_data
);
    import ffha_pkg::*;

    localparam int unsigned OFF_W = $clog2(HEAP_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned SUM_W = OFF_W + CNT_W + 1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_ROT, S_DONE} state_t;

    state_t             state_reg;
    req_item_t          item_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   tail_reg;
    logic               fit_reg, fnd_reg;
    logic [IDX_W-1:0]   fit_idx_reg, fnd_idx_reg;
    logic [OFF_W-1:0]   fit_off_reg, tail_off_reg, prev_off_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               prev_used_reg;
    logic [OFF_W-1:0]   prev_size_reg;
    logic               wr_en_reg;
    logic [IDX_W-1:0]   wr_idx_reg;
    logic [OFF_W-1:0]   wr_size_reg;
    logic               wr_used_reg;
    logic               fr_en_reg;
    logic               nt_en_reg;
    logic [OFF_W-1:0]   nt_off_reg;
    status_t            st_reg;
    logic [ADDR_W-1:0]  ra_reg;
    logic               out_valid_reg;
    rsp_item_t          out_reg;

    logic [OFF_W-1:0] c_off  [MAX_BLOCKS];
    logic [OFF_W-1:0] c_size [MAX_BLOCKS];
    logic             c_used [MAX_BLOCKS];
    logic [OFF_W-1:0] n_off  [MAX_BLOCKS];
    logic [OFF_W-1:0] n_size [MAX_BLOCKS];
    logic             n_used [MAX_BLOCKS];
    logic             shift;
    logic             load0;

    // Cell 0 is the head; ring rotates towards lower indexes. After a full
    // turn of MAX_BLOCKS shifts every entry is back in place.
    assign shift = (state_reg == S_SCAN) || (state_reg == S_ROT);

    logic [IDX_W-1:0] head_idx;
    assign head_idx = pos_reg[IDX_W-1:0];

    always_comb
    begin
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            n_off[k]  = c_off[(k + 1) % MAX_BLOCKS];
            n_size[k] = c_size[(k + 1) % MAX_BLOCKS];
            n_used[k] = c_used[(k + 1) % MAX_BLOCKS];
        end
        // write-back during the second turn as the target entry passes the head
        if (state_reg == S_ROT && fr_en_reg && head_idx == fnd_idx_reg)
            n_used[MAX_BLOCKS-1] = 1'b0;
        if (state_reg == S_ROT && wr_en_reg && head_idx == wr_idx_reg)
        begin
            n_size[MAX_BLOCKS-1] = wr_size_reg;
            n_used[MAX_BLOCKS-1] = wr_used_reg;
        end
        if (state_reg == S_ROT && nt_en_reg && head_idx == IDX_W'(tail_reg + 1'b1))
        begin
            n_off[MAX_BLOCKS-1]  = nt_off_reg;
            n_size[MAX_BLOCKS-1] = '0;
            n_used[MAX_BLOCKS-1] = 1'b0;
        end
    end
    assign load0 = 1'b0;

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        ffha_cell #(.OFF_W(OFF_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .shift(shift), .load(load0),
            .in_offset(n_off[g]), .in_size(n_size[g]), .in_used(n_used[g]),
            .offset(c_off[g]), .size(c_size[g]), .used(c_used[g])
        );
    end

    logic [OFF_W-1:0] req_w, addr_w, hdr_w;
    assign req_w  = OFF_W'(item_reg.request_size);
    assign addr_w = OFF_W'(item_reg.address);
    assign hdr_w  = OFF_W'(HEADER_BYTES);

    logic below_tail, is_target_op, match_here, fit_here;
    assign below_tail   = head_idx < tail_reg;
    assign is_target_op = item_reg.operation == OP_FREE || item_reg.operation == OP_REALLOC;
    assign match_here   = below_tail && !fnd_reg
                          && ({1'b0, c_off[0]} + {1'b0, hdr_w}) == {1'b0, addr_w};
    // realloc frees its own block first, so the matched entry counts as free
    assign fit_here     = below_tail && !fit_reg
                          && (!c_used[0] || (match_here && item_reg.operation == OP_REALLOC))
                          && c_size[0] >= req_w;

    logic [SUM_W-1:0] add_term;
    always_comb
    begin
        add_term = '0;
        if (pos_reg != '0 && IDX_W'(pos_reg - 1'b1) < tail_reg)
        begin
            if (prev_used_reg)
                add_term = SUM_W'(c_off[0]) - SUM_W'(prev_off_reg) - SUM_W'(hdr_w)
                           - SUM_W'(prev_size_reg);
            else
                add_term = SUM_W'(prev_size_reg) + SUM_W'(hdr_w);
        end
    end

    logic [OFF_W-1:0] base_off;
    logic [OFF_W+1:0] p_ext, pr_ext, heap_ext;
    assign base_off = fit_reg ? fit_off_reg : tail_off_reg;
    assign heap_ext = (OFF_W+2)'(HEAP_BYTES);
    assign p_ext    = (OFF_W+2)'(base_off) + (OFF_W+2)'(hdr_w);
    assign pr_ext   = p_ext + (OFF_W+2)'(req_w);

    logic [SUM_W:0]   total;
    logic [SUM_W-1:0] sat_sum;
    assign total   = {1'b0, sum_reg} + (SUM_W+1)'(HEAP_BYTES) - (SUM_W+1)'(tail_off_reg);
    assign sat_sum = (total > (SUM_W+1)'(4095)) ? SUM_W'(4095) : total[SUM_W-1:0];

    status_t           dec_st;
    logic [ADDR_W-1:0] dec_ra;
    logic              dec_fr, dec_wr, dec_nt;

    always_comb
    begin
        dec_st = ST_OK;
        dec_ra = '0;
        dec_fr = 1'b0;
        dec_wr = 1'b0;
        dec_nt = 1'b0;
        if (item_reg.operation != OP_QUERY)
        begin
            if (is_target_op && !fnd_reg)
                dec_st = ST_NOTFOUND;
            else if (item_reg.operation == OP_FREE
                     || (item_reg.operation == OP_REALLOC && item_reg.request_size == '0))
            begin
                dec_fr = 1'b1;
                if (item_reg.operation == OP_REALLOC)
                    dec_ra = item_reg.address;
            end
            else
            begin
                // allocate; a realloc drops its old block whatever the outcome
                dec_fr = is_target_op;
                if (p_ext + {2'b0, req_w} > heap_ext)
                    dec_st = ST_NOSPACE;
                else if (fit_reg)
                begin
                    dec_wr = 1'b1;
                    dec_ra = ADDR_W'(p_ext);
                end
                else if (pr_ext + {2'b0, hdr_w} < heap_ext
                         && (CNT_W+1)'(tail_reg) + 1'b1 < (CNT_W+1)'(MAX_BLOCKS))
                begin
                    dec_wr = 1'b1;
                    dec_nt = 1'b1;
                    dec_ra = ADDR_W'(p_ext);
                end
                else
                    dec_st = ST_NOSPACE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            wr_en_reg     <= 1'b0;
            fr_en_reg     <= 1'b0;
            nt_en_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg  <= in_data;
                        pos_reg   <= '0;
                        fit_reg   <= 1'b0;
                        fnd_reg   <= 1'b0;
                        sum_reg   <= '0;
                        wr_en_reg <= 1'b0;
                        fr_en_reg <= 1'b0;
                        nt_en_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    prev_off_reg  <= c_off[0];
                    prev_size_reg <= c_size[0];
                    prev_used_reg <= c_used[0];
                    sum_reg       <= sum_reg + add_term;
                    if (match_here && is_target_op)
                    begin
                        fnd_reg     <= 1'b1;
                        fnd_idx_reg <= head_idx;
                    end
                    if (fit_here)
                    begin
                        fit_reg     <= 1'b1;
                        fit_idx_reg <= head_idx;
                        fit_off_reg <= c_off[0];
                    end
                    if (head_idx == tail_reg)
                        tail_off_reg <= c_off[0];
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == CNT_W'(MAX_BLOCKS - 1))
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    pos_reg     <= '0;
                    state_reg   <= S_ROT;
                    st_reg      <= dec_st;
                    ra_reg      <= dec_ra;
                    fr_en_reg   <= dec_fr;
                    wr_en_reg   <= dec_wr;
                    nt_en_reg   <= dec_nt;
                    wr_idx_reg  <= fit_reg ? fit_idx_reg : tail_reg;
                    wr_size_reg <= req_w;
                    wr_used_reg <= 1'b1;
                    nt_off_reg  <= OFF_W'(pr_ext);
                end
                S_ROT:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == CNT_W'(MAX_BLOCKS - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_reg.result_address <= ra_reg;
                        out_reg.status         <= st_reg;
                        out_reg.free_bytes     <= (item_reg.operation == OP_QUERY)
                                                  ? FREE_W'(sat_sum) : '0;
                        if (nt_en_reg)
                            tail_reg <= IDX_W'(tail_reg + 1'b1);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W+1)'(tail_reg) < (CNT_W+1)'(MAX_BLOCKS)) else $error("tail out of range");
    a_one_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !(out_valid_reg && !out_ready)) |=> out_valid_reg)
        else $error("result lost");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_OK |-> out_reg.result_address == '0)
        else $error("failed op with address");
`endif

endmodule

@@ rtl/core/ffha_cell.sv @@
// ----------------------------------------------------------------------------
// ffha_cell
// One block-table entry: offset, size and used flag. The entry's contents
// shift one cell a cycle around the ring while the sequencer walks the table.
// ----------------------------------------------------------------------------
module ffha_cell #(
    parameter int unsigned OFF_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic             load,
    input  logic [OFF_W-1:0] in_offset,
    input  logic [OFF_W-1:0] in_size,
    input  logic             in_used,
    output logic [OFF_W-1:0] offset,
    output logic [OFF_W-1:0] size,
    output logic             used
);

    logic [OFF_W-1:0] offset_reg;
    logic [OFF_W-1:0] size_reg;
    logic             used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            used_reg   <= 1'b0;
        end
        else if (shift || load)
        begin
            offset_reg <= in_offset;
            used_reg   <= in_used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift || load)
            size_reg <= in_size;
    end

    assign offset = offset_reg;
    assign size   = size_reg;
    assign used   = used_reg;

endmodule
